>>> rtl/core/btrn_pkg.sv
package btrn_pkg;

   localparam int NumberWidth  = 12;
   localparam int LetterWidth  = 7;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 8;
   localparam int MultWidth    = 14;

   localparam logic [NumberWidth-1:0] MaxValid = 12'd3999;

   // ascii codes of the numeral letters
   localparam logic [LetterWidth-1:0] LetterI = 7'h49;
   localparam logic [LetterWidth-1:0] LetterV = 7'h56;
   localparam logic [LetterWidth-1:0] LetterX = 7'h58;
   localparam logic [LetterWidth-1:0] LetterL = 7'h4C;
   localparam logic [LetterWidth-1:0] LetterC = 7'h43;
   localparam logic [LetterWidth-1:0] LetterD = 7'h44;
   localparam logic [LetterWidth-1:0] LetterM = 7'h4D;

   typedef logic [1:0] place_type;
   typedef logic [3:0] digit_type;
   typedef logic [1:0] slot_type;
   typedef logic [2:0] len_type;
   typedef logic [1:0] code_type;

   // letter roles within a place
   localparam code_type CodeUnit = 2'd0;
   localparam code_type CodeFive = 2'd1;
   localparam code_type CodeNext = 2'd2;

   localparam place_type PlaceOnes      = 2'd0;
   localparam place_type PlaceTens      = 2'd1;
   localparam place_type PlaceHundreds  = 2'd2;
   localparam place_type PlaceThousands = 2'd3;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
      logic emit_err;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic digit_zero;
      logic final_letter;
   } status_type;

   // weight of a place times a digit
   function automatic logic [MultWidth-1:0] place_mult(place_type p, digit_type d);
      logic [MultWidth-1:0] w;
      case (p)
         PlaceOnes:      w = 14'd1;
         PlaceTens:      w = 14'd10;
         PlaceHundreds:  w = 14'd100;
         PlaceThousands: w = 14'd1000;
         default:        w = 14'd0;
      endcase
      return w * MultWidth'(d);
   endfunction

   function automatic len_type digit_len(digit_type d);
      case (d)
         4'd1, 4'd5:       return 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:             return 3'd2;
         4'd3, 4'd7:       return 3'd3;
         4'd8:             return 3'd4;
         default:          return 3'd0;
      endcase
   endfunction

   function automatic code_type digit_code(digit_type d, slot_type k);
      case (d)
         4'd4:                   return (k == 2'd0) ? CodeUnit : CodeFive;
         4'd9:                   return (k == 2'd0) ? CodeUnit : CodeNext;
         4'd5, 4'd6, 4'd7, 4'd8: return (k == 2'd0) ? CodeFive : CodeUnit;
         default:                return CodeUnit;
      endcase
   endfunction

   function automatic logic [LetterWidth-1:0] place_letter(place_type p, code_type c);
      case (p)
         PlaceOnes:
            return (c == CodeFive) ? LetterV : ((c == CodeNext) ? LetterX : LetterI);
         PlaceTens:
            return (c == CodeFive) ? LetterL : ((c == CodeNext) ? LetterC : LetterX);
         PlaceHundreds:
            return (c == CodeFive) ? LetterD : ((c == CodeNext) ? LetterM : LetterC);
         default:
            return LetterM;
      endcase
   endfunction

endpackage

>>> rtl/core/btrn_dpath.sv
module btrn_dpath (
   input  logic                                 clock,
   input  logic [btrn_pkg::ReqDataWidth-1:0]    req_tdata,
   input  btrn_pkg::cmd_type                    cmd,
   output btrn_pkg::status_type                 status,
   output logic [btrn_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);
   import btrn_pkg::*;

   logic [NumberWidth-1:0] rem_ff, rem_in;
   place_type              place_ff, place_in;
   slot_type               slot_ff, slot_in;
   logic [LetterWidth-1:0] letter_ff, letter_in;
   logic                   last_ff, last_in;
   logic                   error_ff, error_in;

   logic [NumberWidth-1:0] number;
   digit_type              digit;
   logic [MultWidth-1:0]   sub_amount;
   logic [NumberWidth-1:0] rem_next;
   logic                   digit_done;
   logic [LetterWidth-1:0] cur_letter;

   assign number = req_tdata[NumberWidth-1:0];

   // digit of the current place from parallel compares against its multiples
   always_comb begin
      digit = 4'd0;
      for (int j = 1; j <= 9; j++) begin
         if ({2'b00, rem_ff} >= place_mult(place_ff, 4'(j))) begin
            digit = 4'(j);
         end
      end
   end

   assign sub_amount = place_mult(place_ff, digit);
   assign rem_next   = rem_ff - sub_amount[NumberWidth-1:0];
   assign digit_done = (({1'b0, slot_ff} + 3'd1) == digit_len(digit));
   assign cur_letter = place_letter(place_ff, digit_code(digit, slot_ff));

   assign status.bad          = (number == '0) || (number > MaxValid);
   assign status.digit_zero   = (digit == 4'd0);
   assign status.final_letter = digit_done && (rem_next == '0);

   always_comb begin
      rem_in    = rem_ff;
      place_in  = place_ff;
      slot_in   = slot_ff;
      letter_in = letter_ff;
      last_in   = last_ff;
      error_in  = error_ff;
      if (cmd.load) begin
         rem_in   = number;
         place_in = PlaceThousands;
         slot_in  = 2'd0;
      end else if (cmd.step) begin
         if (digit_done || status.digit_zero) begin
            rem_in   = rem_next;
            place_in = place_ff - 2'd1;
            slot_in  = 2'd0;
         end else begin
            slot_in = slot_ff + 2'd1;
         end
      end
      if (cmd.emit) begin
         letter_in = cur_letter;
         last_in   = status.final_letter;
         error_in  = 1'b0;
      end else if (cmd.emit_err) begin
         letter_in = '0;
         last_in   = 1'b1;
         error_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      place_ff  <= place_in;
      slot_ff   <= slot_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_tdata = {{(RspDataWidth-LetterWidth){1'b0}}, letter_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = error_ff;

endmodule

>>> rtl/core/btrn_ctrl.sv
module btrn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  btrn_pkg::status_type  status,
   output btrn_pkg::cmd_type     cmd
);
   import btrn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   // output register can take a new item
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.bad ? ST_ERR : ST_RUN;
            end
         end
         ST_RUN: begin
            // zero digits are skipped without an item
            if (status.digit_zero) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               cmd.step = 1'b1;
               if (status.final_letter) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = (cmd.emit || cmd.emit_err) ? 1'b1 :
                         (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_no_double_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.emit_err))
      else $error("letter and error item written in one cycle");

   a_bad_to_err: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.bad) |=> (state_ff == ST_ERR))
      else $error("out of range number did not go to error state");

   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.final_letter) |=> (state_ff == ST_IDLE && rsp_tvalid))
      else $error("final letter did not end the run");

   a_drop_only_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("pending item lost");

endmodule

>>> rtl/core/binary_to_roman_numeral.sv
// the first letter is on rsp from the letter register once the item is
// accepted and any leading zero digits (up to three) are skipped; then one
// letter per cycle while output is free, each zero digit before the last
// letter taking a step of its own; 3888 gives the longest numeral, an out
// of range number one error item; the single letter emitter sets the rate
// reset: synchronous, active high, clears the controller and output valid
module binary_to_roman_numeral (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [btrn_pkg::ReqDataWidth-1:0]    req_tdata,  // [11:0] number
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [btrn_pkg::RspDataWidth-1:0]    rsp_tdata,  // [6:0] letter
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser   // [0] error
);
   import btrn_pkg::*;

   cmd_type    cmd;
   status_type status;

   btrn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   btrn_dpath u_dpath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import btrn_pkg::*;

   typedef struct packed {
      logic [LetterWidth-1:0] letter;
      logic                   last;
      logic                   error;
   } numeral_char_type;

   class numeral_scoreboard;
      numeral_char_type expected_chars[$];
      int               mismatches;

      function new();
         mismatches = 0;
      endfunction

      // spell out one accepted number as the letters it must produce
      function void note_number(input logic [NumberWidth-1:0] number);
         logic [LetterWidth-1:0] spelled[$];
         logic [LetterWidth-1:0] unit_l, five_l, next_l;
         numeral_char_type       ch;
         int                     value, digit, weight;
         value = int'(number);
         if (value == 0 || value > int'(MaxValid)) begin
            ch.letter = '0;
            ch.last   = 1'b1;
            ch.error  = 1'b1;
            expected_chars.push_back(ch);
            return;
         end
         weight = 1000;
         for (int place = 3; place >= 0; place--) begin
            digit = (value / weight) % 10;
            case (place)
               3: begin
                  unit_l = LetterM; five_l = LetterM; next_l = LetterM;
               end
               2: begin
                  unit_l = LetterC; five_l = LetterD; next_l = LetterM;
               end
               1: begin
                  unit_l = LetterX; five_l = LetterL; next_l = LetterC;
               end
               default: begin
                  unit_l = LetterI; five_l = LetterV; next_l = LetterX;
               end
            endcase
            case (digit)
               4: begin
                  spelled.push_back(unit_l);
                  spelled.push_back(five_l);
               end
               9: begin
                  spelled.push_back(unit_l);
                  spelled.push_back(next_l);
               end
               default: begin
                  if (digit >= 5) spelled.push_back(five_l);
                  repeat (digit % 5) spelled.push_back(unit_l);
               end
            endcase
            weight = weight / 10;
         end
         foreach (spelled[i]) begin
            ch.letter = spelled[i];
            ch.last   = (i == spelled.size() - 1);
            ch.error  = 1'b0;
            expected_chars.push_back(ch);
         end
      endfunction

      function void check_char(input logic [LetterWidth-1:0] letter, input logic last,
                               input logic error);
         numeral_char_type want;
         if (expected_chars.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected item: letter %h last %b error %b", letter, last, error);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (want.letter !== letter || want.last !== last || want.error !== error) begin
            if (mismatches < 10)
               $display("expected letter %h last %b error %b, got letter %h last %b error %b",
                        want.letter, want.last, want.error, letter, last, error);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;

   bit                      hold_off = 1'b0;
   numeral_scoreboard       numerals = new();

   binary_to_roman_numeral u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("binary_to_roman_numeral: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         numerals.check_char(rsp_tdata[LetterWidth-1:0], rsp_tlast, rsp_tuser);
   end

   // valid stays high from one item to the next, it only drops for a real gap
   task automatic send_number(input logic [NumberWidth-1:0] number, input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataWidth'(number);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      numerals.note_number(number);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_numerals();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (numerals.pending() != 0) @(posedge clock);
   endtask

   // receiver: changing stall patterns, plus a long hold-off each time one is requested
   initial begin
      int mode, span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 100);
         repeat (span) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [NumberWidth-1:0] directed_numbers[$];
      logic [NumberWidth-1:0] number;
      int                     burst, gap, sel;

      directed_numbers = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd3999, 12'd4000, 12'd4095,
                           12'd3888, 12'd1994, 12'd40, 12'd90, 12'd400, 12'd900, 12'd10,
                           12'd100, 12'd1000, 12'd2048, 12'd444, 12'd999, 12'd49, 12'd14,
                           12'd3000, 12'd2730, 12'd1365};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_numbers[i])
         send_number(directed_numbers[i], $urandom_range(0, 2));
      drain_numerals();

      for (int n = 0; n < 500; ) begin
         burst = $urandom_range(1, 20);
         if (n >= 150 && n < 170 && !hold_off) hold_off = 1'b1;
         if (n >= 400 && n < 420) begin
            drain_numerals();
            n += 20;
         end
         for (int b = 0; b < burst; b++) begin
            sel = $urandom_range(0, 19);
            if (sel < 16)      number = NumberWidth'($urandom_range(1, 3999));
            else if (sel < 17) number = '0;
            else if (sel < 19) number = NumberWidth'($urandom_range(4000, 4095));
            else               number = NumberWidth'($urandom);
            gap = (b == burst - 1 && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            send_number(number, gap);
         end
         n += burst;
      end

      drain_numerals();
      repeat (24) @(posedge clock);
      if (numerals.mismatches == 0 && numerals.pending() == 0)
         $display("binary_to_roman_numeral: match");
      else
         $display("binary_to_roman_numeral: mismatch");
      $finish;
   end

endmodule
